[rtl/fnrf_pkg.sv]
// fnrf_pkg: widths, byte codes and item types for the fasta n-run finder
// used by fasta_n_run_finder and fnrf_checker; no dependencies
package fnrf_pkg;

    localparam int POS_BITS    = 40;
    localparam int RECORD_BITS = 24;

    localparam logic [POS_BITS-1:0]    POS_MAX = {POS_BITS{1'b1}};
    localparam logic [RECORD_BITS-1:0] REC_MAX = {RECORD_BITS{1'b1}};

    localparam logic [7:0] CHAR_UPPER_N = 8'h4E;
    localparam logic [7:0] CHAR_LOWER_N = 8'h6E;
    localparam logic [7:0] CHAR_HEADER  = 8'h3E;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [RECORD_BITS-1:0] record_index;
        logic [POS_BITS-1:0]    run_start;
        logic [POS_BITS-1:0]    run_end;
        logic [POS_BITS-1:0]    run_length;
    } out_item_t;

endpackage

[rtl/fasta_n_run_finder.sv]
// fasta_n_run_finder: top level, finds runs of n bases in a fasta byte stream
// depends on fnrf_pkg
//
// usage:
//   s_ channel takes one item per cycle while s_ready is high: a text byte, or an end-of-stream mark
//   that reports the open run and returns the scan state to zero.
//   m_ channel gives one item per closed run of n/N bases: record index
//   (headers seen so far, saturating), start, exclusive end and length.
//   a run is closed by a '>' header byte, by any other non-blank base, or by
//   end of stream; header lines are skipped up to the newline.
// timing:
//   an accepted item lands in an input register, is decoded against the scan
//   state, and its result (if any) is written to the result register that
//   drives m_. one item per cycle is sustained while no result is stalled, set
//   by the single decode stage between the input and result registers.
// reset: aresetn (synchronous, active low) empties both registers and clears
//   the scan state, so the next byte starts before any header at position 0.
// stall: while m_ready is low the result register holds; items that give no
//   result still flow, and s_ready drops only when a result would be lost.
module fasta_n_run_finder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fnrf_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output fnrf_pkg::out_item_t m_item
);
    import fnrf_pkg::*;

    logic                   in_valid_reg;
    in_item_t               in_item_reg;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_item_reg, out_item_next;

    logic                   in_header_reg, in_header_next;
    logic [POS_BITS-1:0]    base_pos_reg, base_pos_next;
    logic [POS_BITS-1:0]    run_begin_reg, run_begin_next;
    logic [RECORD_BITS-1:0] record_count_reg, record_count_next;

    logic [7:0]             c;
    logic                   is_n, is_blank, is_hdr, is_eos;
    logic                   close_run, run_open, has_result, advance;
    logic [POS_BITS-1:0]    pos_inc;

    assign c        = in_item_reg.data_byte;
    assign is_eos   = in_item_reg.end_of_stream;
    assign is_n     = (c == CHAR_UPPER_N) || (c == CHAR_LOWER_N);
    assign is_hdr   = (c == CHAR_HEADER);
    assign is_blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    assign pos_inc  = (base_pos_reg == POS_MAX) ? POS_MAX : base_pos_reg + 1'b1;
    assign run_open = run_begin_reg < base_pos_reg;

    // a run closes on eos, on '>' or on a non-blank non-n base outside a header
    assign close_run  = is_eos || (!in_header_reg && (is_hdr || (!is_n && !is_blank)));
    assign has_result = close_run && run_open;
    assign advance    = in_valid_reg && (!has_result || !out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || advance;

    always_comb begin
        in_header_next    = in_header_reg;
        base_pos_next     = base_pos_reg;
        run_begin_next    = run_begin_reg;
        record_count_next = record_count_reg;
        if (advance) begin
            if (is_eos) begin
                in_header_next    = 1'b0;
                base_pos_next     = '0;
                run_begin_next    = '0;
                record_count_next = '0;
            end else if (in_header_reg) begin
                if (c == CHAR_NEWLINE) begin
                    in_header_next = 1'b0;
                end
            end else if (is_hdr) begin
                in_header_next = 1'b1;
                base_pos_next  = '0;
                run_begin_next = '0;
                if (record_count_reg != REC_MAX) begin
                    record_count_next = record_count_reg + 1'b1;
                end
            end else if (is_n) begin
                base_pos_next = pos_inc;
            end else if (!is_blank) begin
                base_pos_next  = pos_inc;
                run_begin_next = pos_inc;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (advance && has_result) begin
            out_valid_next             = 1'b1;
            out_item_next.record_index = record_count_reg;
            out_item_next.run_start    = run_begin_reg;
            out_item_next.run_end      = base_pos_reg;
            out_item_next.run_length   = base_pos_reg - run_begin_reg;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            in_header_reg    <= 1'b0;
            base_pos_reg     <= '0;
            run_begin_reg    <= '0;
            record_count_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg    <= out_valid_next;
            in_header_reg    <= in_header_next;
            base_pos_reg     <= base_pos_next;
            run_begin_reg    <= run_begin_next;
            record_count_reg <= record_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        out_item_reg <= out_item_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

[rtl/fnrf_checker.sv]
// fnrf_checker: port-level assertions for fasta_n_run_finder, bound to the top
// depends on fnrf_pkg
module fnrf_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input fnrf_pkg::in_item_t  s_item,
    input logic                m_valid,
    input logic                m_ready,
    input fnrf_pkg::out_item_t m_item
);
    import fnrf_pkg::*;

    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    // interval fields agree and a run is never empty
    a_interval: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.run_length != '0) &&
                    (m_item.run_end == m_item.run_start + m_item.run_length))
        else $error("run interval inconsistent");

    // empty after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a new result needs an earlier accepted input item
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without an accepted input item");

endmodule

bind fasta_n_run_finder fnrf_checker u_fnrf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
